### hdl/irf_pkg.sv
// Shared constants and the item record for the interval reflection fold.
package irf_pkg;

    localparam int WIDTH  = 32;
    localparam int DW     = WIDTH + 2;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    // back pipeline: magnitude stage, one stage per remainder bit, three finishing stages
    localparam int NSTG   = WIDTH + 4;

    typedef struct packed {
        logic                    bypass;
        logic signed [WIDTH-1:0] res;
        logic signed [WIDTH-1:0] lo;
        logic signed [WIDTH-1:0] hi;
        logic signed [DW-1:0]    w;
        logic signed [DW-1:0]    d;
        logic                    neg;
        logic [WIDTH-1:0]        mag;
        logic [DW-1:0]           rem;
    } irf_item_t;

endpackage

### hdl/irf_front.sv
// Front end: takes input transactions, forms width and offset, flags trivial cases.
module irf_front
    import irf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [WIDTH-1:0] value,
    input  logic signed [WIDTH-1:0] low_end,
    input  logic signed [WIDTH-1:0] upper_bound,
    output logic                    push,
    output irf_item_t               push_item,
    input  logic                    q_full
);

    logic      valid_reg;
    logic      valid_next;
    irf_item_t item_reg;
    irf_item_t item_next;
    logic      take;
    logic      empty_iv;
    logic      in_range;

    assign in_stall = valid_reg && q_full;
    assign take     = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;
    assign push_item = item_reg;

    always_comb
    begin
        item_next.lo  = low_end;
        item_next.hi  = upper_bound;
        item_next.w   = DW'(upper_bound) - DW'(low_end);
        item_next.d   = DW'(value) - DW'(low_end);
        item_next.neg = 1'b0;
        item_next.mag = '0;
        item_next.rem = '0;
        empty_iv = (upper_bound <= low_end);
        in_range = (value >= low_end) && (value <= upper_bound);
        item_next.bypass = empty_iv || in_range;
        item_next.res    = empty_iv ? low_end : value;
    end

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### hdl/irf_queue.sv
// Short queue between the front end and the remainder pipeline.
module irf_queue
    import irf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  irf_item_t push_item,
    output logic      full,
    input  logic      pop,
    output irf_item_t pop_item,
    output logic      empty
);

    irf_item_t        mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;

    assign full     = (count_reg == QCW'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/irf_back.sv
// Back end: bit-per-stage remainder pipeline, fold, offset add and clamp.
module irf_back
    import irf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  irf_item_t               q_item,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [WIDTH-1:0] reflected
);

    localparam int LAST_DIV = WIDTH;
    localparam int FIX_NEG  = WIDTH + 1;
    localparam int FOLD     = WIDTH + 2;

    irf_item_t       stg_reg  [NSTG];
    irf_item_t       stg_next [NSTG];
    logic [NSTG-1:0] valid_reg;
    logic            adv;

    assign adv       = !(valid_reg[NSTG-1] && out_stall);
    assign pop       = adv && !q_empty;
    assign out_valid = valid_reg[NSTG-1];
    assign reflected = stg_reg[NSTG-1].res;

    always_comb
    begin
        irf_item_t            src;
        irf_item_t            nxt;
        logic [DW-1:0]        tw;
        logic [DW-1:0]        sh;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] lo_x;
        logic signed [DW-1:0] hi_x;
        for (int k = 0; k < NSTG; k++)
        begin
            src  = (k == 0) ? q_item : stg_reg[(k == 0) ? 0 : k - 1];
            nxt  = src;
            tw   = {src.w[DW-2:0], 1'b0};
            sh   = {src.rem[DW-2:0], src.mag[WIDTH-1]};
            lo_x = DW'(src.lo);
            hi_x = DW'(src.hi);
            y    = lo_x + $signed(src.rem);
            if (k == 0)
            begin
                // split offset into sign and magnitude
                nxt.neg = src.d[DW-1];
                nxt.mag = src.d[DW-1] ? WIDTH'(-src.d) : WIDTH'(src.d);
                nxt.rem = '0;
            end
            else if (k <= LAST_DIV)
            begin
                nxt.mag = {src.mag[WIDTH-2:0], 1'b0};
                nxt.rem = (sh >= tw) ? sh - tw : sh;
            end
            else if (k == FIX_NEG)
            begin
                // make the remainder non-negative for a negative offset
                if (src.neg && (src.rem != '0))
                begin
                    nxt.rem = tw - src.rem;
                end
            end
            else if (k == FOLD)
            begin
                if (src.rem > $unsigned(src.w))
                begin
                    nxt.rem = tw - src.rem;
                end
            end
            else
            begin
                if (!src.bypass)
                begin
                    if (y < lo_x)
                    begin
                        nxt.res = src.lo;
                    end
                    else if (y > hi_x)
                    begin
                        nxt.res = src.hi;
                    end
                    else
                    begin
                        nxt.res = y[WIDTH-1:0];
                    end
                end
            end
            stg_next[k] = nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

endmodule

### hdl/interval_reflection_fold.sv
// Top level of the interval reflection fold.
//
// Folds a signed Q15.16 value into [low_end, upper_bound] by mirroring at
// the ends; an empty or inverted interval returns low_end.
// Input channel: in_valid / in_stall with value, low_end, upper_bound.
// Output channel: out_valid / out_stall with reflected. A transaction moves
// on a rising edge where valid is high and stall is low.
// Throughput: one transaction per cycle while out_stall is low. The offset
// remainder is taken by a pipeline that resolves one dividend bit per stage,
// WIDTH stages long. Path: front register, queue slot, magnitude stage,
// WIDTH remainder stages and three finishing stages.
// Results leave in input order, one per input.
// A stalled output holds its transaction and freezes the back pipeline; the
// four-entry queue then absorbs the front end until full, after which
// in_stall rises. Input is taken while a finished result waits.
// Reset clears all valid state; no result is pending after reset.
module interval_reflection_fold
    import irf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [WIDTH-1:0] value,
    input  logic signed [WIDTH-1:0] low_end,
    input  logic signed [WIDTH-1:0] upper_bound,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [WIDTH-1:0] reflected
);

    logic      push;
    irf_item_t push_item;
    logic      q_full;
    logic      q_empty;
    logic      pop;
    irf_item_t q_item;

    irf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .low_end     (low_end),
        .upper_bound (upper_bound),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    irf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    irf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .reflected (reflected)
    );

endmodule

### hdl/irf_checker.sv
// Port-level checks for the interval reflection fold, bound to the top level.
module irf_checker
    import irf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [WIDTH-1:0] reflected
);

    localparam int CAP = NSTG + QDEPTH + 1;
    localparam int CW  = $clog2(CAP + 2);

    logic [CW-1:0] pend_reg;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + CW'(in_acc) - CW'(out_acc);
        end
    end

    // no result without an outstanding transaction
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != '0))
        else $error("result shown with nothing outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CW'(CAP))
        else $error("more transactions in flight than the block can hold");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == '0) |-> !in_stall)
        else $error("input stalled while the block is empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(reflected)))
        else $error("stalled result changed");

endmodule

bind interval_reflection_fold irf_checker u_irf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .reflected (reflected)
);

### verif/testbench.sv
// Self-checking testbench for the interval reflection fold.
`timescale 1ns / 100ps

module testbench;
    import irf_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 880;
    localparam int STUCK_LIMIT  = 4000;
    localparam int IDLE_PCT     = 12;

    typedef struct {
        logic signed [WIDTH-1:0] value;
        logic signed [WIDTH-1:0] lo;
        logic signed [WIDTH-1:0] hi;
        bit                      drain_first;
    } fold_req_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [WIDTH-1:0] value = '0;
    logic signed [WIDTH-1:0] low_end = '0;
    logic signed [WIDTH-1:0] upper_bound = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [WIDTH-1:0] reflected;

    fold_req_t               pending_reqs[$];
    logic signed [WIDTH-1:0] expected_folds[$];
    logic                    in_taken = 1'b0;
    int                      accepted_in = 0;
    int                      mismatches = 0;
    int                      stuck_cycles = 0;

    interval_reflection_fold dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .low_end     (low_end),
        .upper_bound (upper_bound),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reflected   (reflected)
    );

    always #1 clk = ~clk;

    // Mirror x back into [lo, hi]; differences carry two guard bits.
    function automatic logic signed [WIDTH-1:0] fold_into_interval(
        input logic signed [WIDTH-1:0] x,
        input logic signed [WIDTH-1:0] lo,
        input logic signed [WIDTH-1:0] hi
    );
        logic signed [DW-1:0] xe, loe, hie, span, twice, rem, y;
        xe  = x;
        loe = lo;
        hie = hi;
        span = hie - loe;
        if (span <= 0)
            return lo;
        if (xe >= loe && xe <= hie)
            return x;
        twice = span + span;
        rem = (xe - loe) % twice;
        if (rem < 0)
            rem += twice;
        if (rem > span)
            rem = twice - rem;
        y = loe + rem;
        if (y < loe)
            y = loe;
        else if (y > hie)
            y = hie;
        return y[WIDTH-1:0];
    endfunction

    function automatic logic signed [WIDTH-1:0] saturate_field(input longint v);
        longint top, bottom;
        top    = (longint'(1) <<< (WIDTH - 1)) - 1;
        bottom = -(longint'(1) <<< (WIDTH - 1));
        if (v > top)
            return top[WIDTH-1:0];
        if (v < bottom)
            return bottom[WIDTH-1:0];
        return v[WIDTH-1:0];
    endfunction

    function automatic longint rand_bits(input int nbits);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (nbits <= 0)
            return 0;
        return longint'(r >> (64 - nbits));
    endfunction

    task automatic add_req(input longint v, input longint lo, input longint hi,
                           input bit drain_first);
        fold_req_t req;
        req.value       = saturate_field(v);
        req.lo          = saturate_field(lo);
        req.hi          = saturate_field(hi);
        req.drain_first = drain_first;
        pending_reqs.push_back(req);
    endtask

    // Driver: present the next transaction at the falling edge.
    always @(negedge clk)
    begin : drive
        fold_req_t req;
        logic      next_valid;
        logic      may_idle;
        may_idle   = !(accepted_in >= 400 && accepted_in < 600);
        next_valid = in_valid;
        if (rst_n && (!in_valid || in_taken))
        begin
            next_valid = 1'b0;
            if (pending_reqs.size() != 0
                && !(may_idle && $urandom_range(0, 99) < IDLE_PCT)
                && (!pending_reqs[0].drain_first || expected_folds.size() == 0))
            begin
                req = pending_reqs.pop_front();
                value       <= req.value;
                low_end     <= req.lo;
                upper_bound <= req.hi;
                next_valid  = 1'b1;
            end
        end
        in_valid  <= next_valid;
        out_stall <= rst_n && may_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Monitor: check results and record expectations at the rising edge.
    always @(posedge clk)
    begin : monitor
        logic signed [WIDTH-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_folds.size() == 0)
            begin
                $error("reflected: expected none, actual %0d", reflected);
                mismatches++;
            end
            else
            begin
                want = expected_folds.pop_front();
                if (reflected !== want)
                begin
                    $error("reflected: expected %0d, actual %0d", want, reflected);
                    mismatches++;
                end
            end
        end
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_folds.push_back(fold_into_interval(value, low_end, upper_bound));
            accepted_in++;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin : stimulus
        longint one, lo, hi, x, span, off, tmp, vmax, vmin;
        int     kind;
        one  = longint'(1) <<< 16;
        vmax = (longint'(1) <<< (WIDTH - 1)) - 1;
        vmin = -(longint'(1) <<< (WIDTH - 1));

        // inside, on either end, empty and inverted intervals
        add_req(3 * one / 2, 0, 3 * one, 1'b0);
        add_req(-2 * one, -2 * one, 4 * one, 1'b0);
        add_req(4 * one, -2 * one, 4 * one, 1'b0);
        add_req(one, 5 * one, 5 * one, 1'b0);
        add_req(0, 7 * one, -7 * one, 1'b0);
        // full-range interval and its inverse
        add_req(0, vmin, vmax, 1'b0);
        add_req(vmin, vmin, vmax, 1'b0);
        add_req(vmax, vmin, vmax, 1'b0);
        add_req(1, vmax, vmin, 1'b0);
        // one-ulp intervals, value at the far extreme
        add_req(vmax, 0, 1, 1'b0);
        add_req(vmin, 0, 1, 1'b0);
        add_req(vmax, vmin, vmin + 1, 1'b0);
        add_req(vmin, vmax - 1, vmax, 1'b0);
        // reflection below, above, across several periods, landing on an end
        add_req(-3 * one, 0, 10 * one, 1'b0);
        add_req(13 * one, 0, 10 * one, 1'b0);
        add_req(25 * one, 0, 10 * one, 1'b0);
        add_req(-20 * one, 0, 10 * one, 1'b0);
        add_req(20 * one, 0, 10 * one, 1'b0);
        add_req(30 * one, 0, 10 * one, 1'b0);
        add_req(-37 * one - 5, 0, 10 * one, 1'b0);
        // widest spans that still leave room outside
        add_req(vmin, -1, vmax, 1'b0);
        add_req(vmax, vmin, -1, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 9);
            lo = $signed($urandom);
            hi = $signed($urandom);
            x  = $signed($urandom);
            case (kind)
                2, 3, 4:
                begin
                    if ($urandom_range(0, 1) != 0)
                        lo = $signed($urandom) >>> $urandom_range(0, 20);
                    span = rand_bits($urandom_range(0, 32));
                    hi   = lo + span;
                    off  = rand_bits($urandom_range(0, 34));
                    x    = ($urandom_range(0, 1) != 0) ? lo - off : hi + off;
                end
                5, 6:
                begin
                    if (lo > hi)
                    begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    if (kind == 5)
                        x = lo + (rand_bits(40) % (hi - lo + 1));
                    else
                        x = ($urandom_range(0, 1) != 0) ? lo : hi;
                end
                7:
                begin
                    hi = lo - rand_bits($urandom_range(0, 32));
                end
                8, 9:
                begin
                    lo = $signed($urandom) >>> 12;
                    hi = lo + rand_bits($urandom_range(1, 22));
                    x  = $signed($urandom) >>> $urandom_range(6, 14);
                end
                default: ;
            endcase
            add_req(x, lo, hi, n == 0 || n == RANDOM_ITEMS / 2);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_folds.size() != 0)
            @(posedge clk);
        repeat (WIDTH + 10) @(posedge clk);

        if (mismatches == 0 && expected_folds.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
hdl/irf_pkg.sv
hdl/irf_front.sv
hdl/irf_queue.sv
hdl/irf_back.sv
hdl/interval_reflection_fold.sv
hdl/irf_checker.sv
verif/testbench.sv
